// ===== design/bfsh_pkg.sv =====
// bfsh_pkg: shared constants for the bloom filter with two string hashes
// no dependencies; imported by bloom_filter_two_string_hashes
package bfsh_pkg;

    localparam int FILTER_BITS = 4096;
    localparam int STORE_BYTES = (FILTER_BITS + 7) / 8;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int BIT_IDX_W   = $clog2(FILTER_BITS);

    localparam int HASH_W      = 32;
    localparam int LEN_W       = 13;
    localparam int COUNT_W     = 2;
    localparam int INDEX_W     = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_LENGTH_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT         = 1'd1;

    localparam logic [LEN_W-1:0]   LEN_RESET   = 13'd4096;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 2'd2;

endpackage

// ===== design/bfsh_ram.sv =====
// bfsh_ram: generic single-clock ram, one write port, one registered read port
// no dependencies
module bfsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/bloom_filter_two_string_hashes.sv =====
// bloom_filter_two_string_hashes: bloom filter top level with sax and sdbm key hashes
// depends on bfsh_pkg and bfsh_ram
//
// usage:
//   a request is taken when start is high and busy is low. opcode insert or query
//   carries one key byte (absorbed when byte_valid is high); key_last closes the key.
//   opcode write stores store_byte_value at filter byte store_byte_index.
//   non-last key bytes and filter writes give no result.
//   a key_last request gives exactly one result: done is high for one cycle with
//   found and was_query. with no hashes in use the result follows on the next cycle;
//   otherwise each hash (sax, then sdbm when two are in use) is reduced by a
//   one-bit-per-cycle remainder unit, then the filter ram is read and, for an insert,
//   written back with the bit set; busy stays high until done rises for the last hash.
//   the receiver cannot stall; results are never held.
//   cfg_write updates filter_length_bits or hash_count at any time the block is idle.
//   after reset a clearing pass zeroes the filter ram, one byte per cycle, for
//   STORE_BYTES (512) bytes with busy high; configuration writes are taken meanwhile.
module bloom_filter_two_string_hashes (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      opcode,
    input  logic [7:0]                      key_byte,
    input  logic                            byte_valid,
    input  logic                            key_last,
    input  logic [bfsh_pkg::INDEX_W-1:0]    store_byte_index,
    input  logic [7:0]                      store_byte_value,
    output logic                            done,
    output logic                            found,
    output logic                            was_query,
    input  logic                            cfg_write,
    input  logic [bfsh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfsh_pkg::CFG_DATA_W-1:0] cfg_data
);

    import bfsh_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;

    localparam int DIV_CNT_W = $clog2(HASH_W);

    logic [2:0]           state_reg, state_next;
    logic [LEN_W-1:0]     len_cfg_reg;
    logic [COUNT_W-1:0]   count_cfg_reg;
    logic [HASH_W-1:0]    sax_reg, sax_next;
    logic [HASH_W-1:0]    sdbm_reg, sdbm_next;
    logic [HASH_W-1:0]    sdbm_hold_reg, sdbm_hold_next;
    logic [HASH_W-1:0]    div_reg, div_next;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [STORE_AW-1:0]  clr_addr_reg, clr_addr_next;
    logic                 query_reg, query_next;
    logic                 second_reg, second_next;
    logic                 two_reg, two_next;
    logic                 all_set_reg, all_set_next;
    logic                 done_reg, done_next;
    logic                 found_reg, found_next;
    logic                 was_query_reg, was_query_next;

    logic                 accept;
    logic [LEN_W-1:0]     len_eff;
    logic [COUNT_W-1:0]   count_eff;
    logic [HASH_W-1:0]    sax_upd, sdbm_upd;
    logic [LEN_W:0]       trial;
    logic [LEN_W:0]       trial_diff;
    logic [2:0]           bit_sel;
    logic                 bit_hit;

    logic                 ram_we;
    logic [STORE_AW-1:0]  ram_waddr;
    logic [7:0]           ram_wdata;
    logic [STORE_AW-1:0]  ram_raddr;
    logic [7:0]           ram_rdata;

    bfsh_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign found     = found_reg;
    assign was_query = was_query_reg;

    // saturated configuration
    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_cfg_reg > LEN_W'(FILTER_BITS))
        begin
            len_eff = LEN_W'(FILTER_BITS);
        end
        else
        begin
            len_eff = len_cfg_reg;
        end
        count_eff = (count_cfg_reg > COUNT_MAX) ? COUNT_MAX : count_cfg_reg;
    end

    // running hash updates
    always_comb
    begin
        if (byte_valid)
        begin
            sax_upd  = sax_reg ^ ((sax_reg << 5) + (sax_reg >> 2) + HASH_W'(key_byte));
            sdbm_upd = HASH_W'(key_byte) + (sdbm_reg << 6) + (sdbm_reg << 16) - sdbm_reg;
        end
        else
        begin
            sax_upd  = sax_reg;
            sdbm_upd = sdbm_reg;
        end
    end

    // one remainder bit per cycle
    assign trial      = {rem_reg, div_reg[HASH_W-1]};
    assign trial_diff = trial - {1'b0, len_eff};

    assign bit_sel   = rem_reg[2:0];
    assign bit_hit   = ram_rdata[bit_sel];
    assign ram_raddr = rem_reg[BIT_IDX_W-1:3];

    always_comb
    begin
        state_next     = state_reg;
        sax_next       = sax_reg;
        sdbm_next      = sdbm_reg;
        sdbm_hold_next = sdbm_hold_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        clr_addr_next  = clr_addr_reg;
        query_next     = query_reg;
        second_next    = second_reg;
        two_next       = two_reg;
        all_set_next   = all_set_reg;
        done_next      = 1'b0;
        found_next     = found_reg;
        was_query_next = was_query_reg;
        ram_we         = 1'b0;
        ram_waddr      = clr_addr_reg;
        ram_wdata      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == STORE_AW'(STORE_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_WRITE)
                    begin
                        if ({1'b0, store_byte_index} < (INDEX_W + 1)'(STORE_BYTES))
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = store_byte_index[STORE_AW-1:0];
                            ram_wdata = store_byte_value;
                        end
                    end
                    else if (opcode == OP_INSERT || opcode == OP_QUERY)
                    begin
                        if (key_last)
                        begin
                            sax_next       = '0;
                            sdbm_next      = '0;
                            sdbm_hold_next = sdbm_upd;
                            div_next       = sax_upd;
                            rem_next       = '0;
                            div_cnt_next   = '0;
                            query_next     = (opcode == OP_QUERY);
                            second_next    = 1'b0;
                            two_next       = (count_eff == COUNT_MAX);
                            all_set_next   = 1'b1;
                            if (count_eff == '0)
                            begin
                                done_next      = 1'b1;
                                found_next     = (opcode == OP_QUERY);
                                was_query_next = (opcode == OP_QUERY);
                            end
                            else
                            begin
                                state_next = S_DIV;
                            end
                        end
                        else
                        begin
                            sax_next  = sax_upd;
                            sdbm_next = sdbm_upd;
                        end
                    end
                end
            end
            S_DIV:
            begin
                div_next     = div_reg << 1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (trial >= {1'b0, len_eff})
                begin
                    rem_next = trial_diff[LEN_W-1:0];
                end
                else
                begin
                    rem_next = trial[LEN_W-1:0];
                end
                if (div_cnt_reg == DIV_CNT_W'(HASH_W - 1))
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!query_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ram_raddr;
                    ram_wdata = ram_rdata | (8'd1 << bit_sel);
                end
                all_set_next = all_set_reg && bit_hit;
                if (two_reg && !second_reg)
                begin
                    second_next  = 1'b1;
                    div_next     = sdbm_hold_reg;
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
                else
                begin
                    done_next      = 1'b1;
                    found_next     = query_reg && all_set_reg && bit_hit;
                    was_query_next = query_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            sax_reg       <= '0;
            sdbm_reg      <= '0;
            done_reg      <= 1'b0;
            len_cfg_reg   <= LEN_RESET;
            count_cfg_reg <= COUNT_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            sax_reg      <= sax_next;
            sdbm_reg     <= sdbm_next;
            done_reg     <= done_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_FILTER_LENGTH_BITS: len_cfg_reg   <= cfg_data[LEN_W-1:0];
                    REG_HASH_COUNT:         count_cfg_reg <= cfg_data[COUNT_W-1:0];
                    default:                ;
                endcase
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        sdbm_hold_reg <= sdbm_hold_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        div_cnt_reg   <= div_cnt_next;
        query_reg     <= query_next;
        second_reg    <= second_next;
        two_reg       <= two_next;
        all_set_reg   <= all_set_next;
        found_reg     <= found_next;
        was_query_reg <= was_query_next;
    end

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_CHK || $past(state_reg) == S_IDLE))
        else $error("result strobe without a finished key");

    a_div_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_cnt_reg == DIV_CNT_W'(HASH_W - 1)) |=> state_reg == S_RD)
        else $error("remainder unit did not hand over after the last step");

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |-> rem_reg < len_eff)
        else $error("bit index not below the filter length");

    a_read_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |=> state_reg == S_CHK)
        else $error("ram read not followed by its check");

endmodule
